// ===== sv/u2b_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 to BMP decoder.
// No dependencies; imported by every module of the block.
package u2b_pkg;

    localparam logic [15:0] QMARK = 16'h003F;
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

    // One batch of results caused by a single input item. Every result but the
    // final one is a question mark without the end-of-text flag.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [15:0]      code_point;
        logic             end_of_text;
    } t_batch;

    // Continuation bytes needed after a lead byte, or zero for a byte that is no lead.
    function automatic logic [1:0] lead_need(input logic [7:0] lead);
        logic [1:0] need;
        if ((lead & 8'hE0) == 8'hC0) begin
            need = 2'd1;
        end else if ((lead & 8'hF0) == 8'hE0) begin
            need = 2'd2;
        end else if ((lead & 8'hF8) == 8'hF0) begin
            need = 2'd3;
        end else begin
            need = 2'd0;
        end
        return need;
    endfunction

endpackage

// ===== sv/u2b_decode.sv =====
// Sequence state and single-pass decode of one byte into a result batch.
// Depends on u2b_pkg.
module u2b_decode
    import u2b_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    output t_batch     o_batch
);

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_cnt, n_cnt;
    logic [5:0] r_pay0;
    logic       w_pay0;

    logic [1:0] need;
    logic       cont;
    logic [CNT_W-1:0] n_q;
    logic       f_res;
    logic [15:0] f_cp;
    logic        f_eot;
    logic        f_hold;
    logic [15:0] seq_cp;

    always_comb begin
        need = lead_need(r_lead);
        cont = (i_byte[7:6] == 2'b10);

        // Decode of the byte as the start of something new.
        f_res  = 1'b1;
        f_cp   = QMARK;
        f_eot  = 1'b0;
        f_hold = 1'b0;
        if (i_byte == 8'h00) begin
            f_cp  = 16'h0000;
            f_eot = 1'b1;
        end else if (i_byte[7] == 1'b0) begin
            f_cp = {8'h00, i_byte};
        end else if (lead_need(i_byte) != 2'd0) begin
            f_res  = 1'b0;
            f_hold = 1'b1;
        end

        if (need == 2'd1) begin
            seq_cp = {5'b00000, r_lead[4:0], i_byte[5:0]};
        end else if (need == 2'd2) begin
            seq_cp = {r_lead[3:0], r_pay0, i_byte[5:0]};
        end else begin
            seq_cp = QMARK;
        end

        n_lead    = r_lead;
        n_cnt     = r_cnt;
        w_pay0    = 1'b0;
        n_q       = '0;
        o_batch   = '{count: '0, code_point: QMARK, end_of_text: 1'b0};

        if (r_lead != 8'h00 && cont) begin
            if ({1'b0, r_cnt} + 3'd1 >= {1'b0, need}) begin
                o_batch.count      = CNT_W'(1);
                o_batch.code_point = seq_cp;
                n_lead = 8'h00;
                n_cnt  = 2'd0;
            end else begin
                // Only the first continuation ever feeds a code point; later ones
                // just advance the count of a four-byte sequence.
                w_pay0 = (r_cnt == 2'd0);
                n_cnt  = r_cnt + 2'd1;
            end
        end else begin
            // A broken sequence flushes the lead and each held continuation.
            if (r_lead != 8'h00) begin
                n_q = (r_cnt >= 2'd2) ? CNT_W'(3) : CNT_W'(r_cnt) + CNT_W'(1);
            end
            n_lead = f_hold ? i_byte : 8'h00;
            n_cnt  = 2'd0;
            o_batch.count = n_q + CNT_W'(f_res);
            if (f_res) begin
                o_batch.code_point  = f_cp;
                o_batch.end_of_text = f_eot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 8'h00;
            r_cnt  <= 2'd0;
        end else if (i_adv) begin
            r_lead <= n_lead;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_pay0) begin
            r_pay0 <= i_byte[5:0];
        end
    end

endmodule

// ===== sv/u2b_emit.sv =====
// Result register that hands out one batch, one result item per cycle while
// i_stall is low. Depends on u2b_pkg.
module u2b_emit
    import u2b_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_batch      i_batch,
    input  logic        i_stall,
    output logic        o_free,
    output logic        o_valid,
    output logic [15:0] o_code_point,
    output logic        o_end_of_text,
    output logic        o_last
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_cp;
    logic             r_eot;
    logic             final_one;

    assign final_one = (r_cnt == CNT_W'(1));
    assign o_valid   = (r_cnt != '0);
    assign o_free    = (r_cnt == '0) || (final_one && !i_stall);
    assign o_last    = final_one;
    assign o_code_point  = final_one ? r_cp : QMARK;
    assign o_end_of_text = final_one & r_eot;

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_batch.count;
        end else if (o_valid && !i_stall) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cp  <= i_batch.code_point;
            r_eot <= i_batch.end_of_text;
        end
    end

endmodule

// ===== sv/utf8_to_bmp_codepoint_decoder.sv =====
// UTF-8 byte stream to 16-bit code point decoder, top level.
// Each byte passes the input register, then the decode, into the result register.
// One byte per cycle while each byte gives at most one result and i_stall is low;
// a byte flushing a broken sequence holds the result register until all are taken.
// Reset (synchronous, active low) drops any pending sequence and empties both stages.
// Depends on u2b_pkg, u2b_decode and u2b_emit.
module utf8_to_bmp_codepoint_decoder
    import u2b_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_point,
    output logic        o_end_of_text,
    output logic        o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       emit_free;
    logic       adv;
    logic       take;
    t_batch     batch;

    assign adv     = r_in_valid && emit_free;
    assign o_stall = r_in_valid && !emit_free;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_in_byte;
        end
    end

    u2b_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .o_batch (batch)
    );

    u2b_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (adv),
        .i_batch       (batch),
        .i_stall       (i_stall),
        .o_free        (emit_free),
        .o_valid       (o_valid),
        .o_code_point  (o_code_point),
        .o_end_of_text (o_end_of_text),
        .o_last        (o_last)
    );

endmodule

// ===== tb/sv/utf8_to_bmp_codepoint_decoder_test.sv =====
// Self-checking testbench for the UTF-8 to BMP code point decoder.
// Drives directed and random byte streams, predicts code points in a behavioral
// decoder of its own (typed rows list theirs), and needs only u2b_pkg and the DUT.
`timescale 1ns / 1ps

module utf8_to_bmp_codepoint_decoder_test
    import u2b_pkg::*;
();

    typedef struct packed {
        logic [15:0] code_point;
        logic        end_of_text;
        logic        last;
    } t_cp_result;

    // One stimulus item. Rows marked typed carry their expected results: n results,
    // all question marks except the final one, which holds cp and eot.
    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic [2:0]  n;
        logic [15:0] cp;
        logic        eot;
    } t_text_row;

    localparam int DIR_ROWS = 27;
    localparam t_text_row DIRECTED [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b1, 3'd1, 16'h0000, 1'b1},   // end of text straight after reset
        '{8'h00, 1'b1, 3'd1, 16'h0000, 1'b1},   // repeated zero byte
        '{8'h41, 1'b1, 3'd1, 16'h0041, 1'b0},
        '{8'h7F, 1'b1, 3'd1, 16'h007F, 1'b0},
        '{8'h80, 1'b1, 3'd1, QMARK,    1'b0},   // stray continuation
        '{8'hF8, 1'b1, 3'd1, QMARK,    1'b0},   // bad lead
        '{8'hFF, 1'b1, 3'd1, QMARK,    1'b0},
        '{8'hC2, 1'b0, 3'd0, 16'h0000, 1'b0},   // two-byte sequence
        '{8'hA9, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'hC0, 1'b0, 3'd0, 16'h0000, 1'b0},   // overlong form passes unchecked
        '{8'h80, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'hED, 1'b0, 3'd0, 16'h0000, 1'b0},   // surrogate passes unchecked
        '{8'hA0, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'hEF, 1'b0, 3'd0, 16'h0000, 1'b0},   // largest code point
        '{8'hBF, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'hBF, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'hF0, 1'b0, 3'd0, 16'h0000, 1'b0},   // complete four-byte sequence
        '{8'h9F, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'h98, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'hE2, 1'b0, 3'd0, 16'h0000, 1'b0},   // broken by an ASCII byte
        '{8'h82, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'h41, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'hF0, 1'b0, 3'd0, 16'h0000, 1'b0},   // held bytes flushed by end of text
        '{8'h80, 1'b0, 3'd0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 3'd0, 16'h0000, 1'b0}
    };
    localparam t_text_row FLUSH_END = '{8'h00, 1'b1, 3'd4, 16'h0000, 1'b1};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_code_point;
    logic        o_end_of_text;
    logic        o_last;

    utf8_to_bmp_codepoint_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_end_of_text (o_end_of_text),
        .o_last        (o_last)
    );

    always #4 i_clk = ~i_clk;

    t_text_row  text_q [$];
    t_text_row  cur_row;
    t_cp_result pending_cps [$];
    t_cp_result batch [$];
    t_cp_result got_cp;
    t_cp_result want_cp;
    int         mismatches = 0;
    int         results_seen = 0;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;
    logic       hold_on = 1'b0;

    // Decoder state of the predictor.
    logic [7:0] lead_r;
    logic [1:0] cnt_r;
    logic [5:0] pay_r [0:1];

    task automatic report_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    function automatic int seq_need(input logic [7:0] b);
        casez (b)
            8'b110?????: return 1;
            8'b1110????: return 2;
            8'b11110???: return 3;
            default:     return 0;
        endcase
    endfunction

    task automatic add_cp(input logic [15:0] cp, input logic eot);
        batch.push_back('{cp, eot, 1'b0});
    endtask

    task automatic start_byte(input logic [7:0] b);
        if (b == 8'h00) begin
            add_cp(16'h0000, 1'b1);
        end else if (b < 8'h80) begin
            add_cp({8'h00, b}, 1'b0);
        end else if (seq_need(b) != 0) begin
            lead_r = b;
            cnt_r = 2'd0;
        end else begin
            add_cp(QMARK, 1'b0);
        end
    endtask

    // Works out the results of one byte into batch and advances the state.
    task automatic decode_byte(input logic [7:0] b);
        int need;
        batch.delete();
        if (lead_r != 8'h00) begin
            need = seq_need(lead_r);
            if (b[7:6] == 2'b10) begin
                if (int'(cnt_r) + 1 >= need) begin
                    if (need == 1) begin
                        add_cp({5'd0, lead_r[4:0], b[5:0]}, 1'b0);
                    end else if (need == 2) begin
                        add_cp({lead_r[3:0], pay_r[0], b[5:0]}, 1'b0);
                    end else begin
                        add_cp(QMARK, 1'b0);
                    end
                    lead_r = 8'h00;
                    cnt_r = 2'd0;
                end else begin
                    if (cnt_r < 2) pay_r[cnt_r[0]] = b[5:0];
                    cnt_r = cnt_r + 2'd1;
                end
            end else begin
                // Broken sequence: one question mark for the lead and one per
                // held continuation, then the byte starts afresh.
                add_cp(QMARK, 1'b0);
                for (int i = 0; i < int'(cnt_r) && i < 2; i++) add_cp(QMARK, 1'b0);
                lead_r = 8'h00;
                cnt_r = 2'd0;
                start_byte(b);
            end
        end else begin
            start_byte(b);
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    endtask

    task automatic queue_results(input t_text_row row);
        decode_byte(row.b);
        if (row.typed) begin
            for (int k = 0; k < int'(row.n); k++) begin
                if (k == int'(row.n) - 1) pending_cps.push_back('{row.cp, row.eot, 1'b1});
                else pending_cps.push_back('{QMARK, 1'b0, 1'b0});
            end
        end else begin
            foreach (batch[k]) pending_cps.push_back(batch[k]);
        end
    endtask

    // Sender: offers items from text_q and predicts each accepted one.
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) queue_results(cur_row);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall) begin
            i_valid <= 1'b1;
        end else if (text_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            cur_row = text_q.pop_front();
            i_valid <= 1'b1;
            i_in_byte <= cur_row.b;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            got_cp = '{o_code_point, o_end_of_text, o_last};
            if (pending_cps.size() == 0) begin
                report_mismatch($sformatf("unexpected result cp=%h", got_cp.code_point));
            end else begin
                want_cp = pending_cps.pop_front();
                if (got_cp.code_point !== want_cp.code_point)
                    report_mismatch($sformatf("code_point %h, want %h",
                                              got_cp.code_point, want_cp.code_point));
                if (got_cp.end_of_text !== want_cp.end_of_text)
                    report_mismatch($sformatf("end_of_text %b, want %b",
                                              got_cp.end_of_text, want_cp.end_of_text));
                if (got_cp.last !== want_cp.last)
                    report_mismatch($sformatf("last %b, want %b",
                                              got_cp.last, want_cp.last));
            end
            results_seen++;
        end
        i_stall <= hold_on || ($urandom_range(99) < rcv_idle_pct);
    end

    task automatic push_byte(input logic [7:0] b);
        text_q.push_back('{b, 1'b0, 3'd0, 16'h0000, 1'b0});
    endtask

    function automatic logic [7:0] make_lead(input int need);
        if (need == 1) return {3'b110, 5'($urandom)};
        if (need == 2) return {4'b1110, 4'($urandom)};
        return {5'b11110, 3'($urandom)};
    endfunction

    function automatic logic [7:0] make_cont();
        return {2'b10, 6'($urandom)};
    endfunction

    // Mostly well-formed sequences with random content, plus broken ones and noise.
    task automatic gen_text(input int count);
        int base;
        int pick;
        int need;
        int held;
        logic [7:0] b;
        base = text_q.size();
        while (text_q.size() - base < count) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                push_byte(8'($urandom_range(127, 1)));
            end else if (pick < 78) begin
                need = (pick < 50) ? 1 : (pick < 70) ? 2 : 3;
                push_byte(make_lead(need));
                repeat (need) push_byte(make_cont());
            end else if (pick < 82) begin
                push_byte(8'h00);
            end else if (pick < 92) begin
                need = $urandom_range(3, 1);
                held = $urandom_range(need - 1);
                push_byte(make_lead(need));
                repeat (held) push_byte(make_cont());
                do b = 8'($urandom_range(255)); while (b[7:6] == 2'b10);
                push_byte(b);
            end else begin
                push_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_sent();
        while (text_q.size() != 0 || i_valid) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_cps.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        lead_r = 8'h00;
        cnt_r = 2'd0;
        pay_r[0] = 6'd0;
        pay_r[1] = 6'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct <= 35;
        rcv_idle_pct <= 52;
        for (int r = 0; r < DIR_ROWS; r++) text_q.push_back(DIRECTED[r]);
        text_q.push_back(FLUSH_END);
        gen_text(117);
        wait_sent();
        // The sender stays quiet until everything has come back.
        wait_drained();

        snd_idle_pct <= 52;
        rcv_idle_pct <= 35;
        gen_text(117);
        wait_sent();

        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
        gen_text(118);
        // A long receiver hold-off while the sender keeps offering bytes.
        fork
            begin
                hold_on <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join_none
        wait_sent();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (pending_cps.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_cps.size()));
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/u2b_pkg.sv
sv/u2b_decode.sv
sv/u2b_emit.sv
sv/utf8_to_bmp_codepoint_decoder.sv
tb/sv/utf8_to_bmp_codepoint_decoder_test.sv
